// ===== design/isac_pkg.sv =====
// Shared types and constants for the integer array sorter.
// No dependencies; compile first.
package isac_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                     insert;
        logic                     shift;
        logic signed [DATA_W-1:0] key;
    } cell_ctrl_t;

    // What one cell shows to its neighbours.
    typedef struct packed {
        logic                     valid;
        logic                     gt;
        logic signed [DATA_W-1:0] value;
    } cell_link_t;

endpackage

// ===== design/isac_if.sv =====
// Handshake channels for the integer array sorter: input and result item.
// Depends on isac_pkg.
interface isac_in_if;
    import isac_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface isac_out_if;
    import isac_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     truncated;

    modport source (output valid, output sorted_value, output final_res,
                    output truncated, input ready);
    modport sink   (input valid, input sorted_value, input final_res,
                    input truncated, output ready);
endinterface

// ===== design/isac_cell.sv =====
// One cell of the sorting chain: holds one element, inserts in order, drains left.
// Depends on isac_pkg.
module isac_cell
    import isac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_link_t prev,
    input  cell_link_t next,
    output cell_link_t link
);

    logic                     valid_reg, valid_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     gt;

    assign gt = valid_reg && (value_reg > ctrl.key);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.shift)
        begin
            valid_next = next.valid;
            value_next = next.value;
        end
        else if (ctrl.insert && (gt || !valid_reg))
        begin
            // larger elements move right; the key lands at the boundary
            if (prev.gt)
            begin
                valid_next = 1'b1;
                value_next = prev.value;
            end
            else if (prev.valid)
            begin
                valid_next = 1'b1;
                value_next = ctrl.key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.value = value_reg;

endmodule

// ===== design/integer_array_sorter_core.sv =====
// Top level of the integer array sorter: a chain of insertion cells.
// Depends on isac_pkg, isac_if and isac_cell.
//
//  channel  modport  fields                                  role
//  feed     sink     value, last                             elements of a set
//  result   source   sorted_value, final_res, truncated      sorted elements
//
// Loading takes one element per cycle; each is put in order as it arrives.
// The element flagged last closes the set; the k kept elements, k = min(n, CAPACITY),
// then leave one per cycle from the head of the chain, and feed is not ready until
// the final one is taken. A stall on result holds the chain. Reset empties the chain.
module integer_array_sorter_core
    import isac_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    isac_in_if.sink    feed,
    isac_out_if.source result
);

    typedef enum logic {LOAD, DRAIN} state_t;

    state_t     state_reg, state_next;
    logic       ovf_reg, ovf_next;
    cell_ctrl_t ctrl;
    cell_link_t links [CAPACITY];
    cell_link_t head_prev;
    cell_link_t tail_next;
    logic       feed_fire;
    logic       out_fire;
    logic       full;

    assign full      = links[CAPACITY-1].valid;
    assign feed_fire = feed.valid && feed.ready;
    assign out_fire  = result.valid && result.ready;

    assign feed.ready = (state_reg == LOAD);

    assign ctrl.insert = feed_fire && !full;
    assign ctrl.shift  = out_fire;
    assign ctrl.key    = feed.value;

    assign head_prev.valid = 1'b1;
    assign head_prev.gt    = 1'b0;
    assign head_prev.value = '0;
    assign tail_next.valid = 1'b0;
    assign tail_next.gt    = 1'b0;
    assign tail_next.value = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        isac_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .prev  ((i == 0) ? head_prev : links[(i == 0) ? 0 : i-1]),
            .next  ((i == CAPACITY-1) ? tail_next
                                      : links[(i == CAPACITY-1) ? i : i+1]),
            .link  (links[i])
        );
    end

    assign result.valid        = (state_reg == DRAIN) && links[0].valid;
    assign result.sorted_value = links[0].value;
    assign result.final_res    = !links[1].valid;
    assign result.truncated    = ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            LOAD:
            begin
                if (feed_fire)
                begin
                    // drop the element once the chain is full
                    if (full)
                        ovf_next = 1'b1;
                    if (feed.last)
                        state_next = DRAIN;
                end
            end
            DRAIN:
            begin
                if (out_fire && result.final_res)
                begin
                    state_next = LOAD;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = LOAD;
                ovf_next   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LOAD;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ===== tb/sv/integer_array_sorter_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for integer_array_sorter_core: feeds sets of signed words and
// checks every sorted result against an in-order insertion predictor held in a scoreboard.
// Depends on isac_pkg, isac_if and the sorter RTL.
module integer_array_sorter_core_tb;
    import isac_pkg::*;

    localparam int TOTAL_ITEMS = 330;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 150;
    localparam int HOLD_AFTER  = 30;

    localparam logic signed [DATA_W-1:0] MIN_WORD = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MAX_WORD = 32'sh7fff_ffff;

    typedef enum int {FILL_RANDOM, FILL_NARROW, FILL_EXTREME, FILL_RISING, FILL_FALLING} fill_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
        logic                     truncated;
    } sorted_item_t;

    class sort_board;
        logic signed [DATA_W-1:0] held [CAPACITY];
        int                       held_count;
        bit                       dropped;
        sorted_item_t             due [$];
        int                       mismatches;
        int                       elements;
        int                       sets_closed;
        int                       truncated_sets;
        int                       results_seen;

        function void note_element(logic signed [DATA_W-1:0] v, logic is_last);
            sorted_item_t item;
            int           j;
            elements++;
            if (held_count < CAPACITY)
            begin
                // keep the set in ascending order as it arrives
                j = held_count;
                while (j > 0 && held[j-1] > v)
                begin
                    held[j] = held[j-1];
                    j--;
                end
                held[j] = v;
                held_count++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (!is_last)
                return;
            for (int k = 0; k < held_count; k++)
            begin
                item.sorted_value = held[k];
                item.final_res    = (k == held_count - 1);
                item.truncated    = dropped;
                due.push_back(item);
            end
            sets_closed++;
            if (dropped)
                truncated_sets++;
            held_count = 0;
            dropped    = 1'b0;
        endfunction

        function void check_result(logic signed [DATA_W-1:0] v, logic fin, logic trunc);
            sorted_item_t want;
            results_seen++;
            if (due.size() == 0)
            begin
                $error("unexpected result item: sorted_value %0d", v);
                mismatches++;
                return;
            end
            want = due.pop_front();
            if (v !== want.sorted_value)
            begin
                $error("sorted_value: expected %0d, got %0d", want.sorted_value, v);
                mismatches++;
            end
            if (fin !== want.final_res)
            begin
                $error("final_res: expected %0b, got %0b", want.final_res, fin);
                mismatches++;
            end
            if (trunc !== want.truncated)
            begin
                $error("truncated: expected %0b, got %0b", want.truncated, trunc);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   tx_gap_max;
    int   rx_gap_max;

    isac_in_if  feed_if();
    isac_out_if result_if();

    sort_board board = new;

    integer_array_sorter_core i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_if),
        .result (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [DATA_W-1:0] pick_value(fill_t fill, int idx,
                                                            logic signed [DATA_W-1:0] base);
        case (fill)
            FILL_NARROW:  return $signed($urandom_range(0, 8)) - 4;
            FILL_RISING:  return base + idx * 7;
            FILL_FALLING: return base - idx * 7;
            FILL_EXTREME:
            begin
                case ($urandom_range(0, 6))
                    0:       return MIN_WORD;
                    1:       return MAX_WORD;
                    2:       return MIN_WORD + 1;
                    3:       return MAX_WORD - 1;
                    4:       return -1;
                    5:       return 1;
                    default: return 0;
                endcase
            end
            default:      return $urandom();
        endcase
    endfunction

    task automatic send_element(input logic signed [DATA_W-1:0] v, input logic is_last);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            feed_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        feed_if.valid <= 1'b1;
        feed_if.value <= v;
        feed_if.last  <= is_last;
        do @(posedge clk); while (!feed_if.ready);
        board.note_element(v, is_last);
    endtask

    // hold the feed idle until every pending result has been taken
    task automatic wait_drained();
        feed_if.valid <= 1'b0;
        do @(posedge clk); while (board.due.size() != 0);
    endtask

    initial
    begin
        logic signed [DATA_W-1:0] mixed [5];
        logic signed [DATA_W-1:0] base;
        fill_t                    fill;
        int                       len;
        int                       pick;
        int                       sent;
        int                       set_no;

        mixed = '{0, -1, MAX_WORD, MIN_WORD, -1};
        sent   = 0;
        set_no = 0;
        tx_gap_max = 0;
        rx_gap_max = 0;
        rst_n         <= 1'b0;
        feed_if.valid <= 1'b0;
        feed_if.value <= '0;
        feed_if.last  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-element sets at both ends of the range
        send_element(MIN_WORD, 1'b1);
        send_element(MAX_WORD, 1'b1);
        // extremes with a repeated value
        tx_gap_max = 5;
        rx_gap_max = 5;
        foreach (mixed[i])
            send_element(mixed[i], i == 4);
        // one more than the store holds: the item that closes the set is dropped
        tx_gap_max = 0;
        rx_gap_max = 0;
        for (int i = 0; i <= CAPACITY; i++)
            send_element((8 - i) * 1000003, i == CAPACITY);
        sent = 24;
        wait_drained();

        while (sent < TOTAL_ITEMS)
        begin
            set_no++;
            tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
            rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
            pick = $urandom_range(0, 19);
            if (pick < 3)
                len = CAPACITY;
            else if (pick < 6)
                len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            else
                len = $urandom_range(1, CAPACITY - 1);
            fill = fill_t'($urandom_range(0, 4));
            base = $urandom();
            for (int i = 0; i < len; i++)
                send_element(pick_value(fill, i, base), i == len - 1);
            sent += len;
            if (set_no % 8 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (2 * CAPACITY + 8) @(posedge clk);
        $display("Sorted %0d sets (%0d truncated) from %0d elements; %0d results checked.",
                 board.sets_closed, board.truncated_sets, board.elements, board.results_seen);
        if (board.mismatches == 0 && board.due.size() == 0)
            $display("[integer_array_sorter_core] OK");
        else
            $display("[integer_array_sorter_core] ERROR");
        $finish;
    end

    initial
    begin
        int gap;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
            board.check_result(result_if.sorted_value, result_if.final_res,
                               result_if.truncated);
            // long stall so the chain fills and the feed backs up
            if (board.results_seen == HOLD_AFTER)
            begin
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((feed_if.valid && feed_if.ready) || (result_if.valid && result_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[integer_array_sorter_core] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/isac_pkg.sv
design/isac_if.sv
design/isac_cell.sv
design/integer_array_sorter_core.sv
tb/sv/integer_array_sorter_core_tb.sv
